// ----- sv/wnms_pkg.sv -----
// Shared types, sizes and helpers of the window non-max suppression block.
// No dependencies; the interface, cell and top-level files import this package.
package wnms_pkg;

	// Frame and window limits
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int MAX_RADIUS = 4;

	// Line store: one bank per buffered row
	localparam int RING_ROWS = 2 * MAX_RADIUS + 2;
	localparam int RING_W    = $clog2(RING_ROWS);

	// Chain of column summaries behind the newest one
	localparam int CHAIN_LEN = 2 * MAX_RADIUS;
	localparam int CIDX_W    = $clog2(CHAIN_LEN);

	// Counter widths
	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int ROW_W  = $clog2(MAX_HEIGHT);
	localparam int IROW_W = $clog2(MAX_HEIGHT + MAX_RADIUS + 1);
	localparam int RCNT_W = $clog2(MAX_RADIUS + 1);

	// Fixed field widths
	localparam int SIZE_W   = 11;
	localparam int RADR_W   = 3;
	localparam int POS_W    = 10;
	localparam int DATA_W   = 32;
	localparam int ADDR_W   = 4;

	// Register map (index = paddr[3:2])
	localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [1:0] REG_RADIUS       = 2'd2;
	localparam logic [1:0] REG_SUPPRESSED   = 2'd3;

	typedef logic signed [DATA_W-1:0] sample_t;

	localparam sample_t SAMPLE_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	// One column summary: input row it was built at, column max, center-row pixel
	typedef struct packed {
		logic [IROW_W-1:0] row;
		sample_t           colmax;
		sample_t           center;
	} cell_t;

	function automatic sample_t smax(input sample_t a, input sample_t b);
		return (a > b) ? a : b;
	endfunction

endpackage

// ----- sv/wnms_if.sv -----
// Stream channels of the window non-max suppression block: pixel in, result out.
// Depends on wnms_pkg.
interface wnms_in_if;
	import wnms_pkg::*;
	logic    valid;
	logic    ready;
	sample_t sample;
	logic    drain;
	modport source(output valid, sample, drain, input ready);
	modport sink(input valid, sample, drain, output ready);
endinterface

interface wnms_out_if;
	import wnms_pkg::*;
	logic             valid;
	logic             ready;
	sample_t          result_value;
	logic             was_suppressed;
	logic [POS_W-1:0] column;
	logic [POS_W-1:0] row;
	logic             end_of_frame;
	modport source(output valid, result_value, was_suppressed, column, row, end_of_frame,
		input ready);
	modport sink(input valid, result_value, was_suppressed, column, row, end_of_frame,
		output ready);
endinterface

// ----- sv/wnms_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wnms_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

// ----- sv/wnms_cell.sv -----
// One cell of the column-summary chain: holds a summary, passes it on when
// the chain shifts, and offers its column max when it lies in the window row.
// Depends on wnms_pkg.
module wnms_cell (
	input  logic                        clk,
	input  logic                        shift,
	input  wnms_pkg::cell_t             cell_in,
	input  logic                        tap_en,
	input  logic [wnms_pkg::IROW_W-1:0] center_row,
	output wnms_pkg::cell_t             cell_out,
	output wnms_pkg::sample_t           masked
);
	import wnms_pkg::*;

	cell_t data_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			data_q <= cell_in;
		end
	end

	assign cell_out = data_q;
	// only summaries of the same output row and inside the window count
	assign masked = (tap_en && data_q.row == center_row) ? data_q.colmax : SAMPLE_MIN;
endmodule

// ----- sv/window_non_max_suppression.sv -----
// Window non-max suppression over a raster stream of Q16.16 responses.
// Pipeline: stage-1 registers, stage-2 registers, then the result register, loaded
// for the item that completes a window (radius rows plus radius pixels after it).
// Throughput: one item per cycle, banks read in parallel, while results are taken.
// Reset: position counters cleared, registers to defaults; line store not cleared.
module window_non_max_suppression (
	input  logic                        clk,
	input  logic                        arst_n,
	wnms_in_if.sink                     samples,
	wnms_out_if.source                  results,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [wnms_pkg::ADDR_W-1:0] paddr,
	input  logic [wnms_pkg::DATA_W-1:0] pwdata,
	output logic [wnms_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);
	import wnms_pkg::*;

	localparam int TREE_LVL = $clog2(CHAIN_LEN + 1);
	localparam int TREE_N   = 1 << TREE_LVL;
	localparam int BLVL     = $clog2(RING_ROWS + 1);
	localparam int BANK_N   = 1 << BLVL;

	// configuration
	logic [SIZE_W-1:0] fw_q, fh_q;
	logic [RADR_W-1:0] rad_q;
	sample_t           floor_q;
	logic [1:0]        reg_idx;
	logic              cfg_we, cfg_restart;
	logic [SIZE_W-1:0] eff_w, eff_h;
	logic [RCNT_W-1:0] eff_r;
	logic [RCNT_W:0]   twice_r;

	// position state
	logic [COL_W-1:0]  in_col_q, out_col_q;
	logic [IROW_W-1:0] in_row_q;
	logic [ROW_W-1:0]  out_row_q;
	logic [RING_W-1:0] ring_q;
	logic [RCNT_W-1:0] tail_q;
	logic              accept, body, adv, wr, emit, eof, col_wrap;

	// line banks
	logic [RING_ROWS-1:0] use_b, cen_b;
	sample_t              bank_rd [RING_ROWS];

	// stage 1
	logic                 v_s1, byp_s1, cbyp_s1, emit_s1, eof_s1;
	logic [RING_ROWS-1:0] use_s1, cen_s1;
	sample_t              sample_s1;
	logic [IROW_W-1:0]    row_s1;
	logic [COL_W-1:0]     oc_s1;
	logic [ROW_W-1:0]     or_s1;
	sample_t              colmax, center;
	logic                 s1_move;

	// stage 2
	logic             v_s2, emit_s2, eof_s2, s2_move;
	cell_t            cell_s2, ctr;
	logic [COL_W-1:0] oc_s2;
	logic [ROW_W-1:0] or_s2;
	cell_t            chain_out [CHAIN_LEN];
	sample_t          chain_mask [CHAIN_LEN];
	logic [CHAIN_LEN-1:0] tap_en;
	sample_t          wmax;
	logic             suppress;

	// output register
	logic             out_v_q;
	sample_t          res_q;
	logic             sup_q, eof_q;
	logic [POS_W-1:0] col_q, row_q;

	// configuration port
	assign pready      = 1'b1;
	assign reg_idx     = paddr[ADDR_W-1:2];
	assign cfg_we      = psel && penable && pwrite;
	assign cfg_restart = cfg_we && (reg_idx != REG_SUPPRESSED);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q    <= SIZE_W'(MAX_WIDTH);
			fh_q    <= SIZE_W'(MAX_HEIGHT);
			rad_q   <= RADR_W'(1);
			floor_q <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx)
				REG_FRAME_WIDTH:  fw_q    <= pwdata[SIZE_W-1:0];
				REG_FRAME_HEIGHT: fh_q    <= pwdata[SIZE_W-1:0];
				REG_RADIUS:       rad_q   <= pwdata[RADR_W-1:0];
				REG_SUPPRESSED:   floor_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_FRAME_WIDTH:  prdata = DATA_W'(fw_q);
			REG_FRAME_HEIGHT: prdata = DATA_W'(fh_q);
			REG_RADIUS:       prdata = DATA_W'(rad_q);
			REG_SUPPRESSED:   prdata = floor_q;
			default:          prdata = '0;
		endcase
	end

	// effective geometry
	always_comb begin
		if (fw_q == '0) eff_w = SIZE_W'(1);
		else if (fw_q > SIZE_W'(MAX_WIDTH)) eff_w = SIZE_W'(MAX_WIDTH);
		else eff_w = fw_q;
		if (fh_q == '0) eff_h = SIZE_W'(1);
		else if (fh_q > SIZE_W'(MAX_HEIGHT)) eff_h = SIZE_W'(MAX_HEIGHT);
		else eff_h = fh_q;
		eff_r   = (rad_q > MAX_RADIUS) ? RCNT_W'(MAX_RADIUS) : RCNT_W'(rad_q);
		twice_r = {eff_r, 1'b0};
	end

	// item classification
	assign accept   = samples.valid && samples.ready;
	assign body     = in_row_q < IROW_W'(eff_h);
	assign adv      = accept && !(body && samples.drain);
	assign wr       = accept && body && !samples.drain;
	assign emit     = (in_row_q >= IROW_W'(eff_r)) && (tail_q >= eff_r);
	assign eof      = (SIZE_W'(out_col_q) == eff_w - SIZE_W'(1))
		&& (SIZE_W'(out_row_q) == eff_h - SIZE_W'(1));
	assign col_wrap = (SIZE_W'(in_col_q) + SIZE_W'(1)) >= eff_w;

	// input and output positions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			ring_q    <= '0;
			tail_q    <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (cfg_restart || (adv && emit && eof)) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			ring_q    <= '0;
			tail_q    <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (adv) begin
			if (col_wrap) begin
				in_col_q <= '0;
				in_row_q <= in_row_q + IROW_W'(1);
				ring_q   <= (ring_q == RING_W'(RING_ROWS - 1)) ? '0 : ring_q + RING_W'(1);
			end else begin
				in_col_q <= in_col_q + COL_W'(1);
			end
			if (in_row_q >= IROW_W'(eff_r) && tail_q < eff_r) begin
				tail_q <= tail_q + RCNT_W'(1);
			end
			if (emit) begin
				if ((SIZE_W'(out_col_q) + SIZE_W'(1)) >= eff_w) begin
					out_col_q <= '0;
					out_row_q <= out_row_q + ROW_W'(1);
				end else begin
					out_col_q <= out_col_q + COL_W'(1);
				end
			end
		end
	end

	// which banks hold rows of the column window, and which holds the center row
	always_comb begin
		logic [RING_W-1:0] ring_dist;
		for (int b = 0; b < RING_ROWS; b++) begin
			if (ring_q >= RING_W'(b)) ring_dist = ring_q - RING_W'(b);
			else ring_dist = ring_q + RING_W'(RING_ROWS - b);
			use_b[b] = (ring_dist != '0) && (ring_dist <= twice_r)
				&& (IROW_W'(ring_dist) <= in_row_q)
				&& ((in_row_q - IROW_W'(ring_dist)) < IROW_W'(eff_h));
			cen_b[b] = (eff_r != '0) && (ring_dist == RING_W'(eff_r));
		end
	end

	// line store, one bank per buffered row
	for (genvar b = 0; b < RING_ROWS; b++) begin : g_bank
		wnms_ram #(.WIDTH(DATA_W), .DEPTH(MAX_WIDTH)) u_bank (
			.clk  (clk),
			.we   (wr && (ring_q == RING_W'(b))),
			.waddr(in_col_q),
			.wdata(samples.sample),
			.re   (accept),
			.raddr(in_col_q),
			.rdata(bank_rd[b])
		);
	end

	assign samples.ready = !v_s1 || s1_move;

	// stage 1 registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (samples.ready) begin
			v_s1 <= adv;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			use_s1    <= use_b;
			cen_s1    <= cen_b;
			byp_s1    <= body;
			cbyp_s1   <= (eff_r == '0);
			sample_s1 <= samples.sample;
			row_s1    <= in_row_q;
			emit_s1   <= emit;
			oc_s1     <= out_col_q;
			or_s1     <= out_row_q;
			eof_s1    <= eof;
		end
	end

	// column max over the window rows and the center-row pixel
	always_comb begin
		sample_t t [BANK_N];
		for (int i = 0; i < BANK_N; i++) begin
			t[i] = SAMPLE_MIN;
		end
		for (int i = 0; i < RING_ROWS; i++) begin
			if (use_s1[i]) t[i] = bank_rd[i];
		end
		if (byp_s1) t[RING_ROWS] = sample_s1;
		for (int l = 0; l < BLVL; l++) begin
			for (int i = 0; i < (BANK_N >> (l + 1)); i++) begin
				t[i] = smax(t[2*i], t[2*i+1]);
			end
		end
		colmax = t[0];
		center = sample_s1;
		for (int i = 0; i < RING_ROWS; i++) begin
			if (!cbyp_s1 && cen_s1[i]) center = bank_rd[i];
		end
	end

	assign s1_move = !v_s2 || s2_move;

	// stage 2 registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s1_move) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move && v_s1) begin
			cell_s2.row    <= row_s1;
			cell_s2.colmax <= colmax;
			cell_s2.center <= center;
			emit_s2        <= emit_s1;
			oc_s2          <= oc_s1;
			or_s2          <= or_s1;
			eof_s2         <= eof_s1;
		end
	end

	assign s2_move = v_s2 && (!emit_s2 || !out_v_q || results.ready);

	// center of the window after this item's summary enters the chain
	assign ctr = (eff_r == '0) ? cell_s2 : chain_out[CIDX_W'(eff_r - RCNT_W'(1))];

	// chain of column summaries
	for (genvar k = 0; k < CHAIN_LEN; k++) begin : g_chain
		assign tap_en[k] = (RCNT_W + 1)'(k + 1) <= twice_r;
		wnms_cell u_cell (
			.clk       (clk),
			.shift     (s2_move),
			.cell_in   ((k == 0) ? cell_s2 : chain_out[(k == 0) ? 0 : k - 1]),
			.tap_en    (tap_en[k]),
			.center_row(ctr.row),
			.cell_out  (chain_out[k]),
			.masked    (chain_mask[k])
		);
	end

	// window max across the column summaries of the center row
	always_comb begin
		sample_t t [TREE_N];
		for (int i = 0; i < TREE_N; i++) begin
			t[i] = SAMPLE_MIN;
		end
		t[0] = (cell_s2.row == ctr.row) ? cell_s2.colmax : SAMPLE_MIN;
		for (int i = 0; i < CHAIN_LEN; i++) begin
			t[i+1] = chain_mask[i];
		end
		for (int l = 0; l < TREE_LVL; l++) begin
			for (int i = 0; i < (TREE_N >> (l + 1)); i++) begin
				t[i] = smax(t[2*i], t[2*i+1]);
			end
		end
		wmax     = t[0];
		suppress = (ctr.center > floor_q) && (wmax > ctr.center);
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (s2_move && emit_s2) begin
			out_v_q <= 1'b1;
		end else if (results.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_move && emit_s2) begin
			res_q <= suppress ? floor_q : ctr.center;
			sup_q <= suppress;
			col_q <= POS_W'(oc_s2);
			row_q <= POS_W'(or_s2);
			eof_q <= eof_s2;
		end
	end

	assign results.valid          = out_v_q;
	assign results.result_value   = res_q;
	assign results.was_suppressed = sup_q;
	assign results.column         = col_q;
	assign results.row            = row_q;
	assign results.end_of_frame   = eof_q;

	// checks
	a_center_sel: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> ($onehot(cen_s1) != cbyp_s1))
		else $error("center row select not unique");

	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && emit && eof) |=> (in_col_q == '0 && in_row_q == '0 && out_row_q == '0))
		else $error("counters not cleared after frame end");

	a_tail_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tail_q <= eff_r)
		else $error("start-up counter beyond radius");
endmodule
